// ----- rtl/ray_box_slab_test_unit_assert.svh -----
// Assertion macros shared by the ray/box slab test RTL.
`ifndef RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define RBST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbst assertion failed");

// Check that cons holds in the cycle after ante holds.
`define RBST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbst assertion failed");

`endif

// ----- rtl/rbst_pkg.sv -----
package rbst_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_AXES    = 3;
   // dividend width: numerator magnitude (one bit wider than a coordinate) scaled up
   localparam int DIV_WIDTH   = COORD_WIDTH + 1 + FRAC_BITS;
   // input register, one stage per quotient bit, saturation register
   localparam int PIPE_DEPTH  = DIV_WIDTH + 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic dneg;
      logic zero;
      logic miss;
   } lane_flag_type;

   typedef struct packed {
      coord_type t_enter;
      coord_type t_exit;
      logic      miss;
   } lane_res_type;

endpackage

// ----- rtl/rbst_divider.sv -----
module rbst_divider import rbst_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic                 nneg,
   input  logic [COORD_WIDTH:0] nmag,
   input  logic                 dneg,
   input  logic [COORD_WIDTH-1:0] dmag,
   output coord_type            quot
);

   logic [DIV_WIDTH-1:0]   nq_ff  [0:DIV_WIDTH];
   logic [COORD_WIDTH-1:0] rem_ff [0:DIV_WIDTH];
   logic [COORD_WIDTH-1:0] dm_ff  [0:DIV_WIDTH];
   logic                   neg_ff [0:DIV_WIDTH];
   coord_type              quot_ff;
   coord_type              quot_in;

   // load the scaled numerator
   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff[0]  <= DIV_WIDTH'(nmag) << FRAC_BITS;
         rem_ff[0] <= '0;
         dm_ff[0]  <= dmag;
         neg_ff[0] <= nneg ^ dneg;
      end
   end

   // one restoring step per stage: quotient bits shift in as dividend bits shift out
   for (genvar s = 0; s < DIV_WIDTH; s++) begin : g_step
      logic [COORD_WIDTH:0]   trial;
      logic                   take;
      logic [COORD_WIDTH-1:0] rem_in;
      logic [COORD_WIDTH:0]   diff;

      always_comb begin
         trial  = {rem_ff[s], nq_ff[s][DIV_WIDTH-1]};
         diff   = trial - {1'b0, dm_ff[s]};
         take   = trial >= {1'b0, dm_ff[s]};
         rem_in = take ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[s+1]  <= {nq_ff[s][DIV_WIDTH-2:0], take};
            rem_ff[s+1] <= rem_in;
            dm_ff[s+1]  <= dm_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   // apply sign and saturate
   always_comb begin
      logic [DIV_WIDTH-1:0] q;
      logic hi_any;
      logic pos_ovf;
      logic neg_ovf;
      q       = nq_ff[DIV_WIDTH];
      hi_any  = |q[DIV_WIDTH-1:COORD_WIDTH];
      pos_ovf = hi_any | q[COORD_WIDTH-1];
      neg_ovf = hi_any | (q[COORD_WIDTH-1] & (|q[COORD_WIDTH-2:0]));
      if (neg_ff[DIV_WIDTH]) begin
         quot_in = neg_ovf ? T_MIN : coord_type'(-q[COORD_WIDTH-1:0]);
      end else begin
         quot_in = pos_ovf ? T_MAX : coord_type'(q[COORD_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// ----- rtl/rbst_lane.sv -----
module rbst_lane import rbst_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  coord_type    origin,
   input  coord_type    dir,
   input  coord_type    box_min,
   input  coord_type    box_max,
   output lane_res_type res
);

   logic                   nneg_lo;
   logic                   nneg_hi;
   logic [COORD_WIDTH:0]   nmag_lo;
   logic [COORD_WIDTH:0]   nmag_hi;
   logic [COORD_WIDTH-1:0] dmag;
   lane_flag_type          flag_in;
   lane_flag_type          flag_ff [0:PIPE_DEPTH-1];
   coord_type              t_lo;
   coord_type              t_hi;

   // form numerator magnitudes and divisor magnitude
   always_comb begin
      logic signed [COORD_WIDTH:0] o_w;
      logic signed [COORD_WIDTH:0] lo_w;
      logic signed [COORD_WIDTH:0] hi_w;
      o_w          = (COORD_WIDTH+1)'(origin);
      lo_w         = (COORD_WIDTH+1)'(box_min);
      hi_w         = (COORD_WIDTH+1)'(box_max);
      nneg_lo      = box_min < origin;
      nneg_hi      = box_max < origin;
      nmag_lo      = nneg_lo ? (o_w - lo_w) : (lo_w - o_w);
      nmag_hi      = nneg_hi ? (o_w - hi_w) : (hi_w - o_w);
      dmag         = dir[COORD_WIDTH-1] ? (-dir) : dir;
      flag_in.dneg = dir[COORD_WIDTH-1];
      flag_in.zero = dir == '0;
      flag_in.miss = (dir == '0) && ((origin < box_min) || (box_max < origin));
   end

   rbst_divider u_div_lo (
      .clock (clock),
      .en    (en),
      .nneg  (nneg_lo),
      .nmag  (nmag_lo),
      .dneg  (flag_in.dneg),
      .dmag  (dmag),
      .quot  (t_lo)
   );

   rbst_divider u_div_hi (
      .clock (clock),
      .en    (en),
      .nneg  (nneg_hi),
      .nmag  (nmag_hi),
      .dneg  (flag_in.dneg),
      .dmag  (dmag),
      .quot  (t_hi)
   );

   // carry the axis flags alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff[0] <= flag_in;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            flag_ff[i] <= flag_ff[i-1];
         end
      end
   end

   // swap on negative direction; a zero direction sets no limit
   always_comb begin
      res.miss = flag_ff[PIPE_DEPTH-1].miss;
      if (flag_ff[PIPE_DEPTH-1].zero) begin
         res.t_enter = T_MIN;
         res.t_exit  = T_MAX;
      end else if (flag_ff[PIPE_DEPTH-1].dneg) begin
         res.t_enter = t_hi;
         res.t_exit  = t_lo;
      end else begin
         res.t_enter = t_lo;
         res.t_exit  = t_hi;
      end
   end

endmodule

// ----- rtl/rbst_merge.sv -----
module rbst_merge import rbst_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  lane_res_type res [NUM_AXES],
   output logic         hit,
   output coord_type    t_enter,
   output coord_type    t_exit
);

   logic      hit_ff;
   logic      hit_in;
   coord_type t_enter_ff;
   coord_type t_enter_in;
   coord_type t_exit_ff;
   coord_type t_exit_in;

   // take the latest entry (no earlier than zero) and earliest exit over the axes
   always_comb begin
      logic miss;
      miss       = 1'b0;
      t_enter_in = '0;
      t_exit_in  = T_MAX;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (res[a].t_enter > t_enter_in) begin
            t_enter_in = res[a].t_enter;
         end
         if (res[a].t_exit < t_exit_in) begin
            t_exit_in = res[a].t_exit;
         end
         miss = miss | res[a].miss;
      end
      hit_in = !miss && (t_exit_in >= t_enter_in) && !t_exit_in[COORD_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff     <= hit_in;
         t_enter_ff <= t_enter_in;
         t_exit_ff  <= t_exit_in;
      end
   end

   assign hit     = hit_ff;
   assign t_enter = t_enter_ff;
   assign t_exit  = t_exit_ff;

endmodule

// ----- rtl/ray_box_slab_test_unit.sv -----
// Ray versus axis-aligned box test, slab method, signed Q16.16. One lane per
// axis runs two pipelined restoring dividers (one quotient bit per stage) for
// the slab times; a merge stage keeps the latest entry and earliest exit and
// registers the result. A new word is taken every cycle while req_stall is
// low; from the accepting edge to rsp_valid a word passes the input register,
// 49 divider steps, the saturation register and the result register. The
// whole pipeline holds while a result waits under rsp_stall, so req_stall
// follows rsp_stall when a result is pending.
`include "ray_box_slab_test_unit_assert.svh"

module ray_box_slab_test_unit import rbst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  coord_type req_origin_x,
   input  coord_type req_origin_y,
   input  coord_type req_origin_z,
   input  coord_type req_dir_x,
   input  coord_type req_dir_y,
   input  coord_type req_dir_z,
   input  coord_type req_box_min_x,
   input  coord_type req_box_min_y,
   input  coord_type req_box_min_z,
   input  coord_type req_box_max_x,
   input  coord_type req_box_max_y,
   input  coord_type req_box_max_z,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output logic      rsp_hit,
   output coord_type rsp_t_enter,
   output coord_type rsp_t_exit
);

   logic         adv;
   logic         v_ff [0:PIPE_DEPTH-1];
   logic         rsp_valid_ff;
   coord_type    origin [NUM_AXES];
   coord_type    dir    [NUM_AXES];
   coord_type    bmin   [NUM_AXES];
   coord_type    bmax   [NUM_AXES];
   lane_res_type res    [NUM_AXES];

   // advance everything when the result register is free or drained
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign origin = '{req_origin_x, req_origin_y, req_origin_z};
   assign dir    = '{req_dir_x, req_dir_y, req_dir_z};
   assign bmin   = '{req_box_min_x, req_box_min_y, req_box_min_z};
   assign bmax   = '{req_box_max_x, req_box_max_y, req_box_max_z};

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      rbst_lane u_lane (
         .clock   (clock),
         .en      (adv),
         .origin  (origin[a]),
         .dir     (dir[a]),
         .box_min (bmin[a]),
         .box_max (bmax[a]),
         .res     (res[a])
      );
   end

   rbst_merge u_merge (
      .clock   (clock),
      .en      (adv),
      .res     (res),
      .hit     (rsp_hit),
      .t_enter (rsp_t_enter),
      .t_exit  (rsp_t_exit)
   );

   // track which stages hold a word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            v_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         rsp_valid_ff <= v_ff[PIPE_DEPTH-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RBST_ASSERT_IMPL(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   `RBST_ASSERT_IMPL(a_enter_nonneg, clock, reset, rsp_valid, !rsp_t_enter[COORD_WIDTH-1])
   `RBST_ASSERT_IMPL(a_hit_exit_nonneg, clock, reset, rsp_valid && rsp_hit, !rsp_t_exit[COORD_WIDTH-1])
   `RBST_ASSERT_IMPL(a_hit_order, clock, reset, rsp_valid && rsp_hit, rsp_t_enter <= rsp_t_exit)
   `RBST_ASSERT_NEXT(a_drain, clock, reset, v_ff[PIPE_DEPTH-1] && !req_stall, rsp_valid)

endmodule
